[hdl/smpe_pkg.sv]
// Shared types, constants and helpers of the serial mouse packet encoder.
`timescale 1ns / 1ps

package smpe_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int PKT_MAX     = 5;

   localparam logic [11:0] MAX_X_RESET    = 12'd639;
   localparam logic [11:0] MAX_Y_RESET    = 12'd479;
   localparam logic [6:0]  MAX_STEP_RESET = 7'd2;

   localparam logic [2:0] OFS_DATA = 3'd0;
   localparam logic [2:0] OFS_IIR  = 3'd2;
   localparam logic [2:0] OFS_MCR  = 3'd4;
   localparam logic [2:0] OFS_LSR  = 3'd5;

   localparam logic [7:0] IIR_BASE   = 8'd6;
   localparam logic [7:0] ID_BYTE    = 8'h4D;
   localparam logic [7:0] MS_SYNC    = 8'h40;
   localparam logic [7:0] MSYS_SYNC  = 8'h80;
   localparam logic [7:0] LOW6_MASK  = 8'h3F;

   localparam logic [CNT_W-1:0] MS_LEN   = CNT_W'(3);
   localparam logic [CNT_W-1:0] MSYS_LEN = CNT_W'(5);

   typedef enum logic [1:0] {
      OP_REPORT = 2'd0,
      OP_POLL   = 2'd1,
      OP_READ   = 2'd2,
      OP_WRITE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_MODE     = 2'd0,
      REG_MAX_X    = 2'd1,
      REG_MAX_Y    = 2'd2,
      REG_MAX_STEP = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      KIND_REPORT,
      KIND_POLL,
      KIND_POP,
      KIND_LSR,
      KIND_IIR,
      KIND_ZERO,
      KIND_FLUSH,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [1:0]  buttons;
      logic        irq_pending;
   } cmd_type;

   typedef struct packed {
      logic        protocol_mode;
      logic [11:0] max_x;
      logic [11:0] max_y;
      logic [6:0]  max_step;
   } cfg_type;

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W:0]   delta);
      logic [PTR_W+1:0] sum;
      sum = {2'b00, base} + {1'b0, delta};
      if (sum >= (PTR_W+2)'(QUEUE_DEPTH)) begin
         sum = sum - (PTR_W+2)'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

[hdl/smpe_req_if.sv]
// Request channel interface: one mouse command word per handshake.
`timescale 1ns / 1ps

interface smpe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [11:0] pos_x;
   logic [11:0] pos_y;
   logic [1:0]  buttons;
   logic [2:0]  reg_offset;
   logic        irq_pending;

   modport source (output valid, opcode, pos_x, pos_y, buttons, reg_offset, irq_pending,
                   input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, buttons, reg_offset, irq_pending,
                   output ready);
endinterface

[hdl/smpe_rsp_if.sv]
// Response channel interface: one result word per handshake.
`timescale 1ns / 1ps

interface smpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       irq_request;

   modport source (output valid, read_data, irq_request, input ready);
   modport sink   (input valid, read_data, irq_request, output ready);
endinterface

[hdl/serial_mouse_packet_encoder_top.sv]
// Serial mouse packet encoder: front decoder, command queue, back end and CSRs.
// Each accepted word passes the command queue, then the back end's response register.
// Throughput: one word per cycle while the queue has room; the back end retires one
// command per cycle unless the response stalls; the two-entry queue accepts until full.
// Reset (synchronous, active high) clears position, target, queue pointers and handshakes,
// and loads the configuration defaults; byte queue storage is not cleared.
`timescale 1ns / 1ps

module serial_mouse_packet_encoder_top (
   input  logic        clock,
   input  logic        reset,
   smpe_req_if.sink    req_chan,
   smpe_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   smpe_pkg::cfg_type cfg;
   smpe_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_pop;

   smpe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   smpe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   smpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

[hdl/smpe_csr.sv]
// APB-style configuration registers of the mouse encoder.
`timescale 1ns / 1ps

module smpe_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output smpe_pkg::cfg_type     cfg
);

   smpe_pkg::cfg_type       cfg_ff;
   smpe_pkg::cfg_type       cfg_in;
   smpe_pkg::reg_index_type index;
   logic                    wr_en;

   assign index      = smpe_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            smpe_pkg::REG_MODE:     cfg_in.protocol_mode = csr_pwdata[0];
            smpe_pkg::REG_MAX_X:    cfg_in.max_x         = csr_pwdata[11:0];
            smpe_pkg::REG_MAX_Y:    cfg_in.max_y         = csr_pwdata[11:0];
            smpe_pkg::REG_MAX_STEP: cfg_in.max_step      = csr_pwdata[6:0];
            default:                cfg_in               = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         smpe_pkg::REG_MODE:     csr_prdata = {31'd0, cfg_ff.protocol_mode};
         smpe_pkg::REG_MAX_X:    csr_prdata = {20'd0, cfg_ff.max_x};
         smpe_pkg::REG_MAX_Y:    csr_prdata = {20'd0, cfg_ff.max_y};
         smpe_pkg::REG_MAX_STEP: csr_prdata = {25'd0, cfg_ff.max_step};
         default:                csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.protocol_mode <= 1'b0;
         cfg_ff.max_x         <= smpe_pkg::MAX_X_RESET;
         cfg_ff.max_y         <= smpe_pkg::MAX_Y_RESET;
         cfg_ff.max_step      <= smpe_pkg::MAX_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/smpe_front.sv]
// Front end: accept request words, decode them and hold them in a two-entry queue.
`timescale 1ns / 1ps

module smpe_front (
   input  logic               clock,
   input  logic               reset,
   smpe_req_if.sink           req_chan,
   output logic               cmd_valid,
   output smpe_pkg::cmd_type  cmd,
   input  logic               cmd_pop
);

   smpe_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;
   logic              pop;
   smpe_pkg::cmd_type decoded;
   smpe_pkg::op_type  op;

   assign op = smpe_pkg::op_type'(req_chan.opcode);

   always_comb begin
      decoded.pos_x       = req_chan.pos_x;
      decoded.pos_y       = req_chan.pos_y;
      decoded.buttons     = req_chan.buttons;
      decoded.irq_pending = req_chan.irq_pending;
      unique case (op)
         smpe_pkg::OP_REPORT: decoded.kind = smpe_pkg::KIND_REPORT;
         smpe_pkg::OP_POLL:   decoded.kind = smpe_pkg::KIND_POLL;
         smpe_pkg::OP_READ: begin
            unique case (req_chan.reg_offset)
               smpe_pkg::OFS_DATA: decoded.kind = smpe_pkg::KIND_POP;
               smpe_pkg::OFS_LSR:  decoded.kind = smpe_pkg::KIND_LSR;
               smpe_pkg::OFS_IIR:  decoded.kind = smpe_pkg::KIND_IIR;
               default:            decoded.kind = smpe_pkg::KIND_ZERO;
            endcase
         end
         smpe_pkg::OP_WRITE: begin
            if (req_chan.reg_offset == smpe_pkg::OFS_MCR) begin
               decoded.kind = smpe_pkg::KIND_FLUSH;
            end else begin
               decoded.kind = smpe_pkg::KIND_NOP;
            end
         end
         default: decoded.kind = smpe_pkg::KIND_NOP;
      endcase
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid & req_chan.ready;
   assign cmd_valid      = (count_ff != 2'd0);
   assign pop            = cmd_pop & cmd_valid;
   assign cmd            = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

[hdl/smpe_back.sv]
// Back end: mouse state, packet encoder, byte queue and response register.
`timescale 1ns / 1ps

module smpe_back (
   input  logic               clock,
   input  logic               reset,
   input  smpe_pkg::cfg_type  cfg,
   input  logic               cmd_valid,
   input  smpe_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   smpe_rsp_if.source         rsp_chan
);

   localparam int PTR_W = smpe_pkg::PTR_W;
   localparam int CNT_W = smpe_pkg::CNT_W;
   localparam int PKT_N = smpe_pkg::PKT_MAX;

   logic [11:0]      cur_x_ff, cur_x_in;
   logic [11:0]      cur_y_ff, cur_y_in;
   logic [1:0]       cur_btn_ff, cur_btn_in;
   logic [11:0]      tgt_x_ff, tgt_x_in;
   logic [11:0]      tgt_y_ff, tgt_y_in;
   logic [1:0]       tgt_btn_ff, tgt_btn_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       byte_queue_ff [smpe_pkg::QUEUE_DEPTH];
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_data_ff, out_data_in;
   logic             out_irq_ff, out_irq_in;

   logic             exec;
   logic             queue_empty;
   logic             differ;
   logic [11:0]      clamp_x, clamp_y;
   logic [12:0]      diff_x, diff_y, lim_pos, lim_neg;
   logic [7:0]       step_x, step_y;
   logic [7:0]       pkt [PKT_N];
   logic [PKT_N-1:0] wr_en;
   logic [PTR_W-1:0] wr_addr [PKT_N];
   logic [7:0]       wr_data [PKT_N];

   assign exec        = cmd_valid & (~out_valid_ff | rsp_chan.ready);
   assign cmd_pop     = exec;
   assign queue_empty = (count_ff == '0);

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.read_data   = out_data_ff;
   assign rsp_chan.irq_request = out_irq_ff;

   assign differ  = (cur_x_ff != tgt_x_ff) | (cur_y_ff != tgt_y_ff) | (cur_btn_ff != tgt_btn_ff);
   assign clamp_x = (tgt_x_ff > cfg.max_x) ? cfg.max_x : tgt_x_ff;
   assign clamp_y = (tgt_y_ff > cfg.max_y) ? cfg.max_y : tgt_y_ff;
   assign diff_x  = {1'b0, clamp_x} - {1'b0, cur_x_ff};
   assign diff_y  = {1'b0, clamp_y} - {1'b0, cur_y_ff};
   assign lim_pos = {6'd0, cfg.max_step};
   assign lim_neg = 13'd0 - lim_pos;

   always_comb begin
      if ($signed(diff_x) < $signed(lim_neg)) begin
         step_x = lim_neg[7:0];
      end else if ($signed(diff_x) > $signed(lim_pos)) begin
         step_x = lim_pos[7:0];
      end else begin
         step_x = diff_x[7:0];
      end
      if ($signed(diff_y) < $signed(lim_neg)) begin
         step_y = lim_neg[7:0];
      end else if ($signed(diff_y) > $signed(lim_pos)) begin
         step_y = lim_pos[7:0];
      end else begin
         step_y = diff_y[7:0];
      end
   end

   always_comb begin
      if (!cfg.protocol_mode) begin
         pkt[0] = smpe_pkg::MS_SYNC | {2'b00, tgt_btn_ff[0], tgt_btn_ff[1],
                                       step_y[7:6], step_x[7:6]};
         pkt[1] = step_x & smpe_pkg::LOW6_MASK;
         pkt[2] = step_y & smpe_pkg::LOW6_MASK;
         pkt[3] = 8'd0;
         pkt[4] = 8'd0;
      end else begin
         pkt[0] = smpe_pkg::MSYS_SYNC | {5'd0, ~tgt_btn_ff[0], 1'b1, ~tgt_btn_ff[1]};
         pkt[1] = step_x;
         pkt[2] = 8'd0 - step_y;
         pkt[3] = 8'd0;
         pkt[4] = 8'd0;
      end
   end

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_btn_in   = cur_btn_ff;
      tgt_x_in     = tgt_x_ff;
      tgt_y_in     = tgt_y_ff;
      tgt_btn_in   = tgt_btn_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff & ~rsp_chan.ready;
      out_data_in  = out_data_ff;
      out_irq_in   = out_irq_ff;
      wr_en        = '0;
      for (int k = 0; k < PKT_N; k++) begin
         wr_addr[k] = smpe_pkg::wrap_add(head_ff, (PTR_W+1)'(k));
         wr_data[k] = pkt[k];
      end
      if (exec) begin
         out_valid_in = 1'b1;
         out_data_in  = 8'd0;
         out_irq_in   = 1'b0;
         unique case (cmd.kind)
            smpe_pkg::KIND_REPORT: begin
               tgt_x_in   = cmd.pos_x;
               tgt_y_in   = cmd.pos_y;
               tgt_btn_in = cmd.buttons;
            end
            smpe_pkg::KIND_POLL: begin
               if (differ && queue_empty) begin
                  tgt_x_in   = clamp_x;
                  tgt_y_in   = clamp_y;
                  cur_btn_in = tgt_btn_ff;
                  cur_x_in   = cur_x_ff + {{4{step_x[7]}}, step_x};
                  cur_y_in   = cur_y_ff + {{4{step_y[7]}}, step_y};
                  if (!cfg.protocol_mode) begin
                     count_in = smpe_pkg::MS_LEN;
                     wr_en    = PKT_N'(7);
                  end else begin
                     count_in = smpe_pkg::MSYS_LEN;
                     wr_en    = PKT_N'(31);
                  end
                  out_irq_in = ~cmd.irq_pending;
               end else begin
                  out_irq_in = ~cmd.irq_pending & ~queue_empty;
               end
            end
            smpe_pkg::KIND_POP: begin
               if (!queue_empty) begin
                  out_data_in = byte_queue_ff[head_ff];
                  head_in     = smpe_pkg::wrap_add(head_ff, (PTR_W+1)'(1));
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            smpe_pkg::KIND_LSR: out_data_in = {7'd0, ~queue_empty};
            smpe_pkg::KIND_IIR: out_data_in = smpe_pkg::IIR_BASE + {7'd0, queue_empty};
            smpe_pkg::KIND_FLUSH: begin
               head_in = '0;
               if (!cfg.protocol_mode) begin
                  count_in   = CNT_W'(1);
                  wr_en      = PKT_N'(1);
                  wr_addr[0] = '0;
                  wr_data[0] = smpe_pkg::ID_BYTE;
               end else begin
                  count_in = '0;
               end
            end
            default: out_data_in = 8'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         cur_btn_ff   <= '0;
         tgt_x_ff     <= '0;
         tgt_y_ff     <= '0;
         tgt_btn_ff   <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         cur_btn_ff   <= cur_btn_in;
         tgt_x_ff     <= tgt_x_in;
         tgt_y_ff     <= tgt_y_in;
         tgt_btn_ff   <= tgt_btn_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_irq_ff  <= out_irq_in;
      for (int k = 0; k < PKT_N; k++) begin
         if (wr_en[k]) begin
            byte_queue_ff[wr_addr[k]] <= wr_data[k];
         end
      end
   end

endmodule

[tb/sv/smpe_response_checker.sv]
// Response checker: tracks mouse state and CSRs, predicts and compares each response word.
`timescale 1ns / 1ps

module smpe_response_checker (
   input  logic        clock,
   input  logic        reset,
   smpe_req_if         req_mon,
   smpe_rsp_if         rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          replies_owed
);

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_request;
   } reply_word;

   reply_word          pending_replies[$];
   smpe_pkg::cfg_type  cfg;
   logic [11:0]        cur_x, cur_y, tgt_x, tgt_y;
   logic [1:0]         cur_btn, tgt_btn;
   logic [7:0]         fifo_mem [smpe_pkg::QUEUE_DEPTH];
   int                 fifo_head, fifo_count;

   initial begin
      fail_count   = 0;
      replies_owed = 0;
   end

   function automatic void push_byte(input logic [7:0] value);
      if (fifo_count >= smpe_pkg::QUEUE_DEPTH) begin
         return;
      end
      fifo_mem[(fifo_head + fifo_count) % smpe_pkg::QUEUE_DEPTH] = value;
      fifo_count++;
   endfunction

   function automatic logic [7:0] pop_byte();
      logic [7:0] value;
      if (fifo_count == 0) begin
         return 8'h00;
      end
      value      = fifo_mem[fifo_head];
      fifo_head  = (fifo_head + 1) % smpe_pkg::QUEUE_DEPTH;
      fifo_count--;
      return value;
   endfunction

   function automatic int step_toward(input int target, input int current);
      int delta;
      int limit;
      delta = target - current;
      limit = int'(cfg.max_step);
      if (delta < -limit) begin
         delta = -limit;
      end
      if (delta > limit) begin
         delta = limit;
      end
      return delta;
   endfunction

   function automatic void queue_packet();
      int         dx, dy;
      logic [7:0] a, b, first;
      if (tgt_x > cfg.max_x) begin
         tgt_x = cfg.max_x;
      end
      if (tgt_y > cfg.max_y) begin
         tgt_y = cfg.max_y;
      end
      dx      = step_toward(int'(tgt_x), int'(cur_x));
      dy      = step_toward(int'(tgt_y), int'(cur_y));
      cur_btn = tgt_btn;
      cur_x   = 12'(int'(cur_x) + dx);
      cur_y   = 12'(int'(cur_y) + dy);
      a       = dx[7:0];
      b       = dy[7:0];
      if (cfg.protocol_mode == 1'b0) begin
         first = smpe_pkg::MS_SYNC | {6'b0, a[7:6]} | {4'b0, b[7:6], 2'b0}
               | (cur_btn[0] ? 8'h20 : 8'h00) | (cur_btn[1] ? 8'h10 : 8'h00);
         push_byte(first);
         push_byte(a & smpe_pkg::LOW6_MASK);
         push_byte(b & smpe_pkg::LOW6_MASK);
      end else begin
         first = smpe_pkg::MSYS_SYNC | {5'b0, ~cur_btn[0], 1'b1, ~cur_btn[1]};
         push_byte(first);
         push_byte(a);
         push_byte(8'd0 - b);
         push_byte(8'h00);
         push_byte(8'h00);
      end
   endfunction

   function automatic reply_word mouse_uart_reply(input logic [1:0]  op,
                                                  input logic [11:0] px,
                                                  input logic [11:0] py,
                                                  input logic [1:0]  btn,
                                                  input logic [2:0]  off,
                                                  input logic        pend);
      reply_word r;
      r = '0;
      case (smpe_pkg::op_type'(op))
         smpe_pkg::OP_REPORT: begin
            tgt_x   = px;
            tgt_y   = py;
            tgt_btn = btn;
         end
         smpe_pkg::OP_POLL: begin
            if ((cur_x != tgt_x || cur_y != tgt_y || cur_btn != tgt_btn) && fifo_count == 0) begin
               queue_packet();
            end
            r.irq_request = !pend && fifo_count != 0;
         end
         smpe_pkg::OP_READ: begin
            case (off)
               smpe_pkg::OFS_DATA: r.read_data = pop_byte();
               smpe_pkg::OFS_LSR:  r.read_data = (fifo_count != 0) ? 8'd1 : 8'd0;
               smpe_pkg::OFS_IIR:  r.read_data = smpe_pkg::IIR_BASE
                                                 + ((fifo_count != 0) ? 8'd0 : 8'd1);
               default:            r.read_data = 8'h00;
            endcase
         end
         default: begin
            if (off == smpe_pkg::OFS_MCR) begin
               fifo_count = 0;
               fifo_head  = 0;
               if (cfg.protocol_mode == 1'b0) begin
                  push_byte(smpe_pkg::ID_BYTE);
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      reply_word seen, want;
      if (reset) begin
         cfg.protocol_mode = 1'b0;
         cfg.max_x         = smpe_pkg::MAX_X_RESET;
         cfg.max_y         = smpe_pkg::MAX_Y_RESET;
         cfg.max_step      = smpe_pkg::MAX_STEP_RESET;
         cur_x      = '0;
         cur_y      = '0;
         cur_btn    = '0;
         tgt_x      = '0;
         tgt_y      = '0;
         tgt_btn    = '0;
         fifo_head  = 0;
         fifo_count = 0;
         pending_replies.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.read_data   = rsp_mon.read_data;
            seen.irq_request = rsp_mon.irq_request;
            if (pending_replies.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: response word with no command outstanding: read_data %h irq %b",
                           $realtime, seen.read_data, seen.irq_request);
               end
            end else begin
               want = pending_replies.pop_front();
               if (seen.read_data !== want.read_data || seen.irq_request !== want.irq_request)
               begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch read_data exp %h got %h, irq_request exp %b got %b",
                              $realtime, want.read_data, seen.read_data,
                              want.irq_request, seen.irq_request);
                  end
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (smpe_pkg::reg_index_type'(csr_paddr[3:2]))
               smpe_pkg::REG_MODE:     cfg.protocol_mode = csr_pwdata[0];
               smpe_pkg::REG_MAX_X:    cfg.max_x         = csr_pwdata[11:0];
               smpe_pkg::REG_MAX_Y:    cfg.max_y         = csr_pwdata[11:0];
               smpe_pkg::REG_MAX_STEP: cfg.max_step      = csr_pwdata[6:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_replies.push_back(mouse_uart_reply(req_mon.opcode, req_mon.pos_x,
                                                       req_mon.pos_y, req_mon.buttons,
                                                       req_mon.reg_offset, req_mon.irq_pending));
         end
      end
      replies_owed = pending_replies.size();
   end

endmodule

[tb/sv/testbench.sv]
// Testbench top: clock, reset, command and CSR stimulus, response backpressure and verdict.
`timescale 1ns / 1ps

module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count, replies_owed;
   int          tx_idle_pct = 17;
   int          rx_idle_pct = 70;
   logic [11:0] lim_x = smpe_pkg::MAX_X_RESET;
   logic [11:0] lim_y = smpe_pkg::MAX_Y_RESET;

   smpe_req_if req_bus();
   smpe_rsp_if rsp_bus();

   serial_mouse_packet_encoder_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   smpe_response_checker reply_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .fail_count   (fail_count),
      .replies_owed (replies_owed)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
   end

   initial begin
      #2_000_000;
      $display("FAIL serial_mouse_packet_encoder_top");
      $finish;
   end

   task automatic send_cmd(input logic [1:0]  op,
                           input logic [11:0] px,
                           input logic [11:0] py,
                           input logic [1:0]  btn,
                           input logic [2:0]  off,
                           input logic        pend);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.pos_x       <= px;
      req_bus.pos_y       <= py;
      req_bus.buttons     <= btn;
      req_bus.reg_offset  <= off;
      req_bus.irq_pending <= pend;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // hold off new words until every response is back
   task automatic drain();
      if (replies_owed != 0) begin
         req_bus.valid <= 1'b0;
         while (replies_owed != 0) @(negedge clock);
      end
   endtask

   task automatic write_reg(input smpe_pkg::reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   task automatic set_config(input logic mode, input logic [11:0] mx, input logic [11:0] my,
                             input logic [6:0] step);
      logic [31:0] v;
      drain();
      v = $urandom(); v[0] = mode;
      write_reg(smpe_pkg::REG_MODE, v);
      v = $urandom(); v[11:0] = mx;
      write_reg(smpe_pkg::REG_MAX_X, v);
      v = $urandom(); v[11:0] = my;
      write_reg(smpe_pkg::REG_MAX_Y, v);
      v = $urandom(); v[6:0] = step;
      write_reg(smpe_pkg::REG_MAX_STEP, v);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      lim_x = mx;
      lim_y = my;
   endtask

   function automatic logic [11:0] pick_coord(input logic [11:0] lim);
      case ($urandom_range(3, 0))
         0: return 12'($urandom());
         1: return 12'($urandom_range(int'(lim), 0));
         2: return (lim > 12'd4087) ? 12'd4095 : lim + 12'($urandom_range(8, 1));
         default: return 12'($urandom_range(15, 0));
      endcase
   endfunction

   task automatic run_phase(input int count);
      int sent;
      int pops;
      int polls;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9, 0) < 7) begin
            send_cmd(smpe_pkg::OP_REPORT, pick_coord(lim_x), pick_coord(lim_y),
                     2'($urandom()), 3'($urandom()), 1'($urandom()));
            sent++;
            polls = $urandom_range(3, 1);
            repeat (polls) begin
               send_cmd(smpe_pkg::OP_POLL, 12'($urandom()), 12'($urandom()), 2'($urandom()),
                        3'($urandom()), $urandom_range(3, 0) == 0);
               pops = $urandom_range(6, 0);
               repeat (pops) begin
                  send_cmd(smpe_pkg::OP_READ, 12'($urandom()), 12'($urandom()),
                           2'($urandom()),
                           ($urandom_range(9, 0) < 7) ? smpe_pkg::OFS_DATA : 3'($urandom()),
                           1'($urandom()));
               end
               sent += 1 + pops;
            end
            if ($urandom_range(11, 0) == 0) begin
               send_cmd(smpe_pkg::OP_WRITE, 12'($urandom()), 12'($urandom()), 2'($urandom()),
                        smpe_pkg::OFS_MCR, 1'($urandom()));
               sent++;
            end
         end else begin
            send_cmd(2'($urandom()), 12'($urandom()), 12'($urandom()), 2'($urandom()),
                     3'($urandom()), 1'($urandom()));
            sent++;
         end
      end
   endtask

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.opcode      = smpe_pkg::OP_REPORT;
      req_bus.pos_x       = '0;
      req_bus.pos_y       = '0;
      req_bus.buttons     = '0;
      req_bus.reg_offset  = '0;
      req_bus.irq_pending = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // empty queue: pop, status reads, poll with nothing to send
      send_cmd(smpe_pkg::OP_READ, 12'd0, 12'd0, 2'b00, smpe_pkg::OFS_DATA, 1'b0);
      send_cmd(smpe_pkg::OP_READ, 12'hFFF, 12'hFFF, 2'b11, smpe_pkg::OFS_IIR, 1'b1);
      send_cmd(smpe_pkg::OP_READ, 12'd0, 12'd0, 2'b00, smpe_pkg::OFS_LSR, 1'b0);
      send_cmd(smpe_pkg::OP_POLL, 12'd0, 12'd0, 2'b00, smpe_pkg::OFS_DATA, 1'b0);
      // target above clamp, then polls with and without a pending interrupt
      send_cmd(smpe_pkg::OP_REPORT, 12'hFFF, 12'hFFF, 2'b11, 3'd7, 1'b1);
      send_cmd(smpe_pkg::OP_POLL, 12'd0, 12'd0, 2'b00, smpe_pkg::OFS_DATA, 1'b0);
      send_cmd(smpe_pkg::OP_POLL, 12'd0, 12'd0, 2'b00, smpe_pkg::OFS_DATA, 1'b1);
      send_cmd(smpe_pkg::OP_READ, 12'd0, 12'd0, 2'b00, smpe_pkg::OFS_LSR, 1'b0);
      send_cmd(smpe_pkg::OP_READ, 12'd0, 12'd0, 2'b00, smpe_pkg::OFS_IIR, 1'b0);
      repeat (4) send_cmd(smpe_pkg::OP_READ, 12'd0, 12'd0, 2'b00, smpe_pkg::OFS_DATA, 1'b0);
      // flush with identification byte, ignored write
      send_cmd(smpe_pkg::OP_WRITE, 12'd0, 12'd0, 2'b00, smpe_pkg::OFS_MCR, 1'b0);
      send_cmd(smpe_pkg::OP_WRITE, 12'hFFF, 12'hFFF, 2'b11, smpe_pkg::OFS_LSR, 1'b1);
      send_cmd(smpe_pkg::OP_READ, 12'd0, 12'd0, 2'b00, smpe_pkg::OFS_DATA, 1'b0);
      for (int k = 1; k < 8; k++) begin
         if (3'(k) != smpe_pkg::OFS_IIR && 3'(k) != smpe_pkg::OFS_LSR) begin
            send_cmd(smpe_pkg::OP_READ, 12'd0, 12'd0, 2'b00, 3'(k), 1'b0);
         end
      end
      // negative step back toward the origin
      send_cmd(smpe_pkg::OP_REPORT, 12'd0, 12'd0, 2'b00, 3'd0, 1'b0);
      send_cmd(smpe_pkg::OP_POLL, 12'd0, 12'd0, 2'b00, smpe_pkg::OFS_DATA, 1'b0);
      repeat (3) send_cmd(smpe_pkg::OP_READ, 12'd0, 12'd0, 2'b00, smpe_pkg::OFS_DATA, 1'b0);

      run_phase(100);
      set_config(1'b1, 12'd4095, 12'd4095, 7'd127);
      run_phase(100);

      tx_idle_pct = 70;
      rx_idle_pct = 17;
      // clamp drops below the current position
      set_config(1'b0, 12'd0, 12'd0, 7'd1);
      run_phase(100);
      // zero step: packets without movement
      set_config(1'b1, 12'd4095, 12'd4095, 7'd0);
      run_phase(50);
      drain();
      run_phase(50);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_config(1'b0, 12'($urandom()), 12'($urandom()), 7'($urandom_range(127, 1)));
      run_phase(100);
      set_config(1'b1, 12'($urandom()), 12'($urandom()), 7'($urandom_range(127, 1)));
      run_phase(100);
      set_config(1'b0, smpe_pkg::MAX_X_RESET, smpe_pkg::MAX_Y_RESET, smpe_pkg::MAX_STEP_RESET);
      run_phase(100);

      req_bus.valid <= 1'b0;
      while (replies_owed != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0 && replies_owed == 0) begin
         $display("PASS serial_mouse_packet_encoder_top");
      end else begin
         $display("FAIL serial_mouse_packet_encoder_top");
      end
      $finish;
   end

endmodule
